@@ design/fmpd_pkg.sv @@
// Shared types, constants and the arctangent step table of the FM phase discriminator.
// Depends on nothing; imported by the mixer, the CORDIC cell and the top level.
package fmpd_pkg;

   localparam logic [31:0] PI_Q29 = 32'd1686629713;
   localparam int unsigned ATAN_TAB_DEPTH = 10;

   localparam logic [31:0] ATAN_TAB [ATAN_TAB_DEPTH] = '{
      32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510843,
      32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        ang;
      logic               zero;
      logic               frame_end;
   } cordic_type;

   function automatic logic [31:0] stage_angle(input int unsigned idx);
      logic [31:0] result;
      result = '0;
      if (idx < ATAN_TAB_DEPTH) begin
         result = ATAN_TAB[idx];
      end else if (idx <= 29) begin
         result = 32'd1 << (29 - idx);
      end
      return result;
   endfunction

endpackage

@@ design/fm_phase_discriminator_core.sv @@
// Top level of the FM phase discriminator: mixer, a row of CORDIC cells, output negation.
// Depends on fmpd_pkg, fmpd_mix and fmpd_cordic_cell.
//
//   channel  ports                                      direction
//   req      req_valid req_stall req_i_sample            in
//            req_q_sample req_frame_end
//   rsp      rsp_valid rsp_stall rsp_freq_out            out
//            rsp_frame_end_out
//
// One item per cycle while rsp_stall is low; three mixer/fold stages, one register per
// CORDIC cell and one output register lie between request and response.
// Reset clears all valid bits and the stored previous sample.
// A stalled result holds; stages behind it fill empty slots, then req_stall rises.
module fm_phase_discriminator_core
   import fmpd_pkg::*;
#(
   parameter int unsigned CORDIC_STAGES = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_i_sample,
   input  logic signed [31:0] req_q_sample,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_freq_out,
   output logic               rsp_frame_end_out
);

   logic       chain_valid [CORDIC_STAGES+1];
   logic       chain_ready [CORDIC_STAGES+1];
   cordic_type chain_data  [CORDIC_STAGES+1];

   logic        mix_ready;
   logic        out_ready;
   logic        rsp_valid_ff;
   logic [31:0] freq_ff, freq_in;
   logic        fe_ff;

   assign req_stall = !mix_ready;

   fmpd_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (mix_ready),
      .in_i         (req_i_sample),
      .in_q         (req_q_sample),
      .in_frame_end (req_frame_end),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_data     (chain_data[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      fmpd_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   assign out_ready                   = !rsp_valid_ff || !rsp_stall;
   assign chain_ready[CORDIC_STAGES] = out_ready;
   assign freq_in = chain_data[CORDIC_STAGES].zero ? 32'd0
                                                   : 32'd0 - chain_data[CORDIC_STAGES].ang;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         freq_ff <= freq_in;
         fe_ff   <= chain_data[CORDIC_STAGES].frame_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_freq_out      = freq_ff;
   assign rsp_frame_end_out = fe_ff;

endmodule

@@ design/fmpd_mix.sv @@
// Conjugate product of the new and the previous sample and the atan2 fold stage.
// Three register stages: products, sums, fold/halve. Uses fmpd_pkg.
module fmpd_mix
   import fmpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [31:0] in_i,
   input  logic signed [31:0] in_q,
   input  logic               in_frame_end,
   output logic               out_valid,
   input  logic               out_ready,
   output cordic_type         out_data
);

   logic signed [31:0] prev_i_ff, prev_q_ff;

   logic               a_valid_ff;
   logic signed [31:0] a_iqp_ff, a_qip_ff, a_iip_ff, a_qqp_ff;
   logic               a_fe_ff;
   logic               a_ready;

   logic               b_valid_ff;
   logic [31:0]        b_num_ff, b_den_ff;
   logic               b_fe_ff;
   logic               b_ready;

   logic               c_valid_ff;
   cordic_type         c_data_ff, c_data_in;
   logic               c_ready;

   logic signed [63:0] p_iqp, p_qip, p_iip, p_qqp;
   logic [31:0]        neg_num, neg_den, fx, fy, fang;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign p_iqp = in_i * prev_q_ff;
   assign p_qip = in_q * prev_i_ff;
   assign p_iip = in_i * prev_i_ff;
   assign p_qqp = in_q * prev_q_ff;

   always_comb begin
      neg_num = 32'd0 - b_num_ff;
      neg_den = 32'd0 - b_den_ff;
      fx      = b_den_ff;
      fy      = b_num_ff;
      fang    = '0;
      if (b_den_ff[31]) begin
         fx   = neg_den;
         fy   = neg_num;
         fang = (neg_num[31] || neg_num == 32'd0) ? PI_Q29 : (32'd0 - PI_Q29);
      end
      c_data_in.x         = $signed(fx) >>> 1;
      c_data_in.y         = $signed(fy) >>> 1;
      c_data_in.ang       = fang;
      c_data_in.zero      = (b_num_ff | b_den_ff) == 32'd0;
      c_data_in.frame_end = b_fe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_i_ff  <= '0;
         prev_q_ff  <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (in_valid && a_ready) begin
            prev_i_ff <= in_i;
            prev_q_ff <= in_q;
         end
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_iqp_ff <= p_iqp[63:32];
         a_qip_ff <= p_qip[63:32];
         a_iip_ff <= p_iip[63:32];
         a_qqp_ff <= p_qqp[63:32];
         a_fe_ff  <= in_frame_end;
      end
      if (b_ready) begin
         b_num_ff <= a_iqp_ff - a_qip_ff;
         b_den_ff <= a_iip_ff + a_qqp_ff;
         b_fe_ff  <= a_fe_ff;
      end
      if (c_ready) begin
         c_data_ff <= c_data_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_data_ff;

endmodule

@@ design/fmpd_cordic_cell.sv @@
// One CORDIC vectoring cell: rotates by plus or minus atan(2^-STAGE) and registers the item.
// Uses fmpd_pkg for the item type and the step angle.
module fmpd_cordic_cell
   import fmpd_pkg::*;
#(
   parameter int unsigned STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   localparam logic [31:0] ANGLE = stage_angle(STAGE);

   logic       valid_ff;
   cordic_type data_ff, data_in;
   logic signed [31:0] xs, ys;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs      = in_data.x >>> STAGE;
      ys      = in_data.y >>> STAGE;
      data_in = in_data;
      if (!in_data.y[31]) begin
         data_in.x   = in_data.x + ys;
         data_in.y   = in_data.y - xs;
         data_in.ang = in_data.ang + ANGLE;
      end else begin
         data_in.x   = in_data.x - ys;
         data_in.y   = in_data.y + xs;
         data_in.ang = in_data.ang - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
